// ===== hdl/tcg_pkg.sv =====
package tcg_pkg;

    // Generator constants (phase in Q0.24, levels in Q0.16)
    localparam logic [23:0] HUE_STEP    = 24'd4835794;
    localparam logic [23:0] PHASE_RESET = 24'd11943100;  // first step lands on 1678
    localparam logic [15:0] VAL_DROP    = 16'd1751;
    localparam logic [15:0] VAL_FLOOR   = 16'd32768;
    localparam logic [15:0] VAL_WRAP    = 16'd27525;
    localparam logic [15:0] SAT_RISE    = 16'd11964;
    localparam logic [15:0] SAT_CEIL    = 16'd55705;
    localparam logic [15:0] SAT_FALL    = 16'd29491;
    localparam logic [15:0] SAT_RESET   = 16'd55705;
    localparam logic [15:0] VAL_RESET   = 16'd60293;

    // Warp: floor(n / 3328) = floor((n >> 8) / 13), done as multiply by
    // ceil(2^24 / 13) and shift; exact for the whole range of n >> 8.
    localparam int          WARP_SHIFT = 24;
    localparam logic [20:0] WARP_RECIP = 21'd1290556;

    // Queue depth between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One classified item: hue to convert plus the levels in force for it
    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] val;
    } tcg_item_t;

endpackage

// ===== hdl/tcg_front.sv =====
module tcg_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         hue_in,
    input  logic                use_gen,
    output logic                push_valid,
    input  logic                push_ready,
    output tcg_pkg::tcg_item_t  push_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_WARP = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [23:0] phase_reg, phase_next;
    logic        stepped_reg, stepped_next;
    logic [15:0] sat_reg, sat_next;
    logic [15:0] val_reg, val_next;
    logic [19:0] y_reg;
    logic [15:0] hue_reg;

    logic        accept;
    logic [16:0] val_drop;
    logic [16:0] val_wrap;
    logic [16:0] sat_rise;
    logic [26:0] x5;
    logic [27:0] x10;
    logic [27:0] warp_n;
    logic [40:0] warp_prod;

    assign in_ready   = (state_reg == F_IDLE);
    assign accept     = in_valid && in_ready;
    assign push_valid = (state_reg == F_PUSH);
    assign push_item  = '{hue: hue_reg, sat: sat_reg, val: val_reg};

    // Generator state step, taken in the transfer cycle
    always_comb begin
        phase_next   = phase_reg;
        stepped_next = stepped_reg;
        sat_next     = sat_reg;
        val_next     = val_reg;
        val_drop     = {1'b0, val_reg} - {1'b0, tcg_pkg::VAL_DROP};
        val_wrap     = {1'b0, val_reg} + {1'b0, tcg_pkg::VAL_WRAP}
                       - {1'b0, tcg_pkg::VAL_DROP};
        sat_rise     = {1'b0, sat_reg} + {1'b0, tcg_pkg::SAT_RISE};
        if (accept && use_gen) begin
            phase_next   = phase_reg + tcg_pkg::HUE_STEP;
            stepped_next = 1'b1;
            if (stepped_reg) begin
                if (val_drop[16] || (val_drop[15:0] < tcg_pkg::VAL_FLOOR)) begin
                    val_next = val_wrap[15:0];
                    if (sat_rise > {1'b0, tcg_pkg::SAT_CEIL}) begin
                        sat_next = 16'(sat_rise - {1'b0, tcg_pkg::SAT_FALL});
                    end else begin
                        sat_next = sat_rise[15:0];
                    end
                end else begin
                    val_next = val_drop[15:0];
                end
            end
        end
    end

    // Piecewise warp numerator from the stepped phase
    always_comb begin
        x5  = {3'b0, phase_reg} + {1'b0, phase_reg, 2'b0};
        x10 = {x5, 1'b0};
        if (x5 < 27'd16777216) begin
            warp_n = x10;
        end else if (!phase_reg[23]) begin
            warp_n = {x10[26:0], 1'b0} - 28'd33554432;
        end else begin
            warp_n = x10 + 28'd50331648;
        end
    end

    assign warp_prod = {21'b0, y_reg} * {20'b0, tcg_pkg::WARP_RECIP};

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = use_gen ? F_WARP : F_PUSH;
                end
            end
            F_WARP: state_next = F_MUL;
            F_MUL:  state_next = F_PUSH;
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            phase_reg   <= tcg_pkg::PHASE_RESET;
            stepped_reg <= 1'b0;
            sat_reg     <= tcg_pkg::SAT_RESET;
            val_reg     <= tcg_pkg::VAL_RESET;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            stepped_reg <= stepped_next;
            sat_reg     <= sat_next;
            val_reg     <= val_next;
        end
    end

    // Hue payload: direct hue or warped phase
    always_ff @(posedge aclk) begin
        if (state_reg == F_WARP) begin
            y_reg <= warp_n[27:8];
        end
        if (accept && !use_gen) begin
            hue_reg <= hue_in;
        end else if (state_reg == F_MUL) begin
            hue_reg <= warp_prod[tcg_pkg::WARP_SHIFT +: 16];
        end
    end

endmodule

// ===== hdl/tcg_queue.sv =====
module tcg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  tcg_pkg::tcg_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tcg_pkg::tcg_item_t  pop_item
);

    tcg_pkg::tcg_item_t         mem [tcg_pkg::Q_DEPTH];
    logic [tcg_pkg::Q_AW-1:0]   wr_ptr_reg;
    logic [tcg_pkg::Q_AW-1:0]   rd_ptr_reg;
    logic [tcg_pkg::Q_AW:0]     count_reg;
    logic                       do_push;
    logic                       do_pop;

    assign push_ready = (count_reg != (tcg_pkg::Q_AW + 1)'(tcg_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/tcg_back.sv =====
module tcg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  tcg_pkg::tcg_item_t  pop_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         out_data
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIFF = 2'd1;
    localparam logic [1:0] B_RAMP = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;

    logic [1:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] vs_prod_reg;
    logic [15:0] val_reg;
    logic [15:0] hue_reg;
    logic [2:0]  sector_reg;
    logic [15:0] frac_reg;
    logic [15:0] d_reg;
    logic [15:0] lower_reg;
    logic [31:0] fd_prod_reg;
    logic [63:0] out_data_reg;

    logic        take;
    logic        load_out;
    logic [18:0] hue_x6;
    logic [16:0] d_round;
    logic [15:0] d_val;
    logic [16:0] ramp_round;
    logic [15:0] ramp;
    logic [15:0] rise;
    logic [15:0] fall;
    logic [15:0] red, green, blue;

    assign pop_ready = (state_reg == B_IDLE);
    assign take      = pop_valid && pop_ready;
    assign load_out  = (state_reg == B_OUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sector and fraction of the hue circle
    assign hue_x6 = {1'b0, pop_item.hue, 2'b0} + {2'b0, pop_item.hue, 1'b0};

    // Chroma span d = round(v*s), clamped to v
    always_comb begin
        d_round = 17'(({1'b0, vs_prod_reg} + 33'd32768) >> 16);
        d_val   = (d_round > {1'b0, val_reg}) ? val_reg : d_round[15:0];
    end

    // Ramp, rising and falling channels, sector select
    always_comb begin
        ramp_round = 17'(({1'b0, fd_prod_reg} + 33'd32768) >> 16);
        ramp       = (ramp_round > {1'b0, d_reg}) ? d_reg : ramp_round[15:0];
        rise       = lower_reg + ramp;
        fall       = val_reg - ramp;
        case (sector_reg)
            SECT_0: begin
                red = val_reg;   green = rise;      blue = lower_reg;
            end
            SECT_1: begin
                red = fall;      green = val_reg;   blue = lower_reg;
            end
            SECT_2: begin
                red = lower_reg; green = val_reg;   blue = rise;
            end
            SECT_3: begin
                red = lower_reg; green = fall;      blue = val_reg;
            end
            SECT_4: begin
                red = rise;      green = lower_reg; blue = val_reg;
            end
            default: begin
                red = val_reg;   green = lower_reg; blue = fall;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (take) begin
                    state_next = B_DIFF;
                end
            end
            B_DIFF: state_next = B_RAMP;
            B_RAMP: state_next = B_OUT;
            B_OUT: begin
                if (load_out) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Output register holds a result until its transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (take) begin
            vs_prod_reg <= {16'b0, pop_item.val} * {16'b0, pop_item.sat};
            val_reg     <= pop_item.val;
            hue_reg     <= pop_item.hue;
            sector_reg  <= hue_x6[18:16];
            frac_reg    <= hue_x6[15:0];
        end
        if (state_reg == B_DIFF) begin
            d_reg     <= d_val;
            lower_reg <= val_reg - d_val;
        end
        if (state_reg == B_RAMP) begin
            fd_prod_reg <= {16'b0, frac_reg} * {16'b0, d_reg};
        end
        if (load_out) begin
            out_data_reg <= {hue_reg, blue, green, red};
        end
    end

endmodule

// ===== hdl/trace_color_generator_hsv_rgb.sv =====
// Trace color generator: each input transfer either carries a hue (Q0.16)
// or, with s_tuser set, asks the internal generator for the next hue, which
// also advances the kept value and saturation levels after the first such
// request. Every input gives one result transfer with red, green, blue and
// the hue used, all Q0.16. A front sequencer steps the generator and warps
// its phase, a two-entry queue follows, and a back sequencer does the
// HSV-to-RGB conversion through its two chained multiplies (v*s, then
// fraction*span). Each sequencer takes a new item only once it has passed
// on the last one. The result sits in an output register, so the block
// keeps taking input while it waits, until the queue and back side fill.
module trace_color_generator_hsv_rgb (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] hue_in
    input  logic        s_tuser,    // [0] use_generator
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata     // [15:0] red, [31:16] green, [47:32] blue,
                                    // [63:48] hue_used
);

    logic               push_valid;
    logic               push_ready;
    tcg_pkg::tcg_item_t push_item;
    logic               pop_valid;
    logic               pop_ready;
    tcg_pkg::tcg_item_t pop_item;

    // Front: accept, generator step, hue warp
    tcg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue_in     (s_tdata),
        .use_gen    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue between the two sides
    tcg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: HSV to RGB conversion and output register
    tcg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== bench/tcg_color_checker.sv =====
// Watches both channels of the trace color generator, keeps its own copy of
// the hue generator and the saturation/value levels, predicts the color of
// each accepted input and compares each result against the oldest prediction.
module tcg_color_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] hue_in
    input  logic        s_tuser,    // [0] use_generator
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // [15:0] red, [31:16] green, [47:32] blue,
                                    // [63:48] hue_used
    output int          mismatch_count,
    output int          pending_count,
    output int          checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Generator constants: phase in Q0.24, levels in Q0.16
    localparam logic [23:0] PHASE_STEP  = 24'd4835794;
    localparam int          FIRST_PHASE = 1678;
    localparam logic [23:0] PHASE_START = 24'(FIRST_PHASE - 4835794);
    localparam logic [15:0] VAL_DROP    = 16'd1751;
    localparam logic [15:0] VAL_FLOOR   = 16'd32768;
    localparam logic [15:0] VAL_WRAP    = 16'd27525;
    localparam logic [15:0] SAT_RISE    = 16'd11964;
    localparam logic [15:0] SAT_CEIL    = 16'd55705;
    localparam logic [15:0] SAT_FALL    = 16'd29491;
    localparam logic [15:0] SAT_START   = 16'd55705;
    localparam logic [15:0] VAL_START   = 16'd60293;
    localparam longint      PHASE_ONE   = 64'd16777216;

    // Same layout as m_tdata, red in the low bits
    typedef struct packed {
        logic [15:0] hue_used;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } color_t;

    logic [23:0] hue_phase;
    logic        stepped_once;
    logic [15:0] saturation_level;
    logic [15:0] value_level;
    color_t      expected_colors[$];

    // Piecewise warp of the Q0.24 phase, truncated to a Q0.16 hue
    function automatic logic [15:0] warp_phase_to_hue(logic [23:0] x);
        logic [63:0] xs;
        logic [63:0] n;
        xs = 64'(x);
        if (xs * 5 < PHASE_ONE)
            n = xs * 10;
        else if (xs * 2 < PHASE_ONE)
            n = xs * 20 - 2 * PHASE_ONE;
        else
            n = xs * 10 + 3 * PHASE_ONE;
        return 16'(n / 3328);
    endfunction

    // Step the generator; also lowers and wraps the levels after the first call
    function automatic logic [15:0] next_generated_hue();
        logic [31:0] v;
        logic [31:0] s;
        hue_phase = hue_phase + PHASE_STEP;
        if (stepped_once) begin
            v = 32'(value_level) - 32'(VAL_DROP);
            if (value_level < VAL_DROP || v < 32'(VAL_FLOOR)) begin
                v = 32'(value_level) + 32'(VAL_WRAP) - 32'(VAL_DROP);
                s = 32'(saturation_level) + 32'(SAT_RISE);
                if (s > 32'(SAT_CEIL))
                    s = s - 32'(SAT_FALL);
                saturation_level = s[15:0];
            end
            value_level = v[15:0];
        end
        stepped_once = 1'b1;
        return warp_phase_to_hue(hue_phase);
    endfunction

    // Six-sector piecewise-linear HSV to RGB
    function automatic color_t shade_hue(logic [15:0] hue, logic [15:0] sat,
                                         logic [15:0] val);
        logic [31:0] v;
        logic [31:0] span;
        logic [31:0] lower;
        logic [31:0] t;
        logic [31:0] sector;
        logic [31:0] frac;
        logic [31:0] ramp;
        logic [31:0] rise;
        logic [31:0] fall;
        color_t      c;
        v = 32'(val);
        span = 32'((64'(val) * 64'(sat) + 64'd32768) >> 16);
        if (span > v)
            span = v;
        lower = v - span;
        t = 32'(hue) * 6;
        sector = t >> 16;
        frac = t & 32'h0000_FFFF;
        ramp = 32'((64'(frac) * 64'(span) + 64'd32768) >> 16);
        if (ramp > span)
            ramp = span;
        rise = lower + ramp;
        fall = v - ramp;
        case (sector)
            0: begin
                c.red = v[15:0];     c.green = rise[15:0];  c.blue = lower[15:0];
            end
            1: begin
                c.red = fall[15:0];  c.green = v[15:0];     c.blue = lower[15:0];
            end
            2: begin
                c.red = lower[15:0]; c.green = v[15:0];     c.blue = rise[15:0];
            end
            3: begin
                c.red = lower[15:0]; c.green = fall[15:0];  c.blue = v[15:0];
            end
            4: begin
                c.red = rise[15:0];  c.green = lower[15:0]; c.blue = v[15:0];
            end
            default: begin
                c.red = v[15:0];     c.green = lower[15:0]; c.blue = fall[15:0];
            end
        endcase
        c.hue_used = hue;
        return c;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // Predict on each input transfer, compare on each result transfer
    always @(posedge aclk) begin
        logic [15:0] hue;
        color_t      got;
        color_t      want;
        if (!aresetn) begin
            hue_phase        = PHASE_START;
            stepped_once     = 1'b0;
            saturation_level = SAT_START;
            value_level      = VAL_START;
            expected_colors.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                hue = s_tuser ? next_generated_hue() : s_tdata;
                expected_colors.push_back(shade_hue(hue, saturation_level, value_level));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_colors.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none got %h",
                             $time, m_tdata);
                end else begin
                    want = expected_colors.pop_front();
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    check_field("hue_used", want.hue_used, got.hue_used);
                end
                checked_count++;
            end
        end
        pending_count = expected_colors.size();
    end

endmodule

// ===== bench/tb_trace_color_generator_hsv_rgb.sv =====
module tb_trace_color_generator_hsv_rgb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;       // [15:0] hue_in
    logic        s_tuser;       // [0] use_generator
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;       // [15:0] red, [31:16] green, [47:32] blue,
                                // [63:48] hue_used
    int          mismatch_count;
    int          pending_count;
    int          checked_count;
    int          generated_sent;
    int          direct_sent;
    int          quiet_cycles;

    always #6 aclk = ~aclk;

    trace_color_generator_hsv_rgb uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tcg_color_checker color_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    // Watchdog: cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side backpressure: open runs, random stalls, long stalls
    initial begin
        int mode;
        int len;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 9);
            len = $urandom_range(4, 60);
            if (mode < 3) begin
                m_tready <= 1'b1;
                repeat (len) @(negedge aclk);
            end else if (mode < 9) begin
                repeat (len) begin
                    m_tready <= ($urandom_range(0, 99) < 65);
                    @(negedge aclk);
                end
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(negedge aclk);
            end
        end
    end

    // Present one item from a falling edge and hold it until the transfer
    task automatic send_item(logic [15:0] hue, logic use_gen);
        s_tvalid <= 1'b1;
        s_tdata  <= hue;
        s_tuser  <= use_gen;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (use_gen)
            generated_sent++;
        else
            direct_sent++;
    endtask

    task automatic idle_input(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(negedge aclk);
        end
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    // Hue on or next to a sector edge; edge k starts at ceil(k*65536/6)
    function automatic logic [15:0] edge_hue(int k, int offset);
        return 16'((k * 65536 + 5) / 6 + offset);
    endfunction

    function automatic logic [15:0] pick_hue();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return edge_hue($urandom_range(0, 5), $urandom_range(0, 2) - 1);
        else if (r == 1)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    initial begin
        int burst_left;
        int gen_pct;
        bit gapless;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        generated_sent = 0;
        direct_sent    = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // First generator step after reset, with a non-zero hue_in to ignore
        send_item(16'hFFFF, 1'b1);
        // Full-scale hues and both sides of every sector edge
        for (int k = 0; k < 6; k++) begin
            send_item(edge_hue(k, -1), 1'b0);
            idle_input(k % 3);
            send_item(edge_hue(k, 0), 1'b0);
        end
        send_item(16'h0000, 1'b1);
        send_item(16'h5555, 1'b1);
        send_item(16'hAAAA, 1'b0);
        idle_input(5);
        send_item(16'h5555, 1'b0);

        // Random bursts with varying generator share and gap policy
        burst_left = 0;
        gen_pct = 50;
        gapless = 1'b0;
        while (generated_sent + direct_sent < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: gen_pct = 10;
                    1: gen_pct = 50;
                    default: gen_pct = 90;
                endcase
                gapless = ($urandom_range(0, 3) == 0);
            end
            send_item(pick_hue(), ($urandom_range(0, 99) < gen_pct));
            if (!gapless)
                idle_input(pick_gap());
            burst_left--;
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d input transfers: %0d generated hues, %0d direct hues",
                 generated_sent + direct_sent, generated_sent, direct_sent);
        $display("Compared %0d results field by field, %0d field mismatches",
                 checked_count, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
